// File: design/bpcw_pkg.sv
package bpcw_pkg;

	localparam int COORD_BITS     = 13;
	localparam int CLICK_BITS     = 12;
	localparam int SUM_BITS       = 20;
	localparam int RATIO_BITS     = 17;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 17;
	localparam int IN_TDATA_BITS  = 80;
	localparam int OUT_TDATA_BITS = 72;
	localparam int COUNT_BITS     = 8;
	localparam int INDEX_BITS     = 7;
	localparam int WIN_BITS       = 23;
	localparam int DEF_MAX_BOXES  = 128;
	localparam int HALF_PAD       = 15;
	localparam int EMPTY_DIV      = 10;

	localparam logic [CFG_IDX_BITS-1:0] CFG_PIC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PIC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RATIO  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RATIO  = 2'd3;

	localparam logic [COORD_BITS-1:0] RST_PIC_WIDTH  = 13'd640;
	localparam logic [COORD_BITS-1:0] RST_PIC_HEIGHT = 13'd480;
	localparam logic [RATIO_BITS-1:0] RST_MIN_RATIO  = 17'd66;
	localparam logic [RATIO_BITS-1:0] RST_MAX_RATIO  = 17'd52429;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MUL_WH,
		ST_MUL_PA,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADD_DEC,
		ST_SCAN,
		ST_WIN_HIT,
		ST_DIVA_START,
		ST_DIVA_WAIT,
		ST_DIVB_START,
		ST_DIVB_WAIT,
		ST_WIN_DIV,
		ST_FIT1,
		ST_FIT2,
		ST_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLEAR,
		OP_MUL_WH,
		OP_MUL_PA,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_ADD_DEC,
		OP_SCAN,
		OP_WIN_HIT,
		OP_DIV_START_A,
		OP_DIV_WAIT_A,
		OP_DIV_START_B,
		OP_DIV_WAIT_B,
		OP_WIN_DIV,
		OP_FIT1,
		OP_FIT2,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic cnt_zero;
		logic scan_done;
		logic found;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// File: design/bpcw_div.sv
module bpcw_div #(
	parameter int DVD_W = 20,
	parameter int DVS_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W:0]    rem_sh;
	logic              q_bit;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		q_bit  = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			if (q_bit) begin
				rem_q <= DVS_W'(rem_sh - {1'b0, dvs_q});
			end else begin
				rem_q <= rem_sh[DVS_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// File: design/bpcw_datapath.sv
module bpcw_datapath #(
	parameter int MAX_BOXES = bpcw_pkg::DEF_MAX_BOXES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bpcw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [bpcw_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic [bpcw_pkg::IN_TDATA_BITS-1:0]   s_tdata,
	input  bpcw_pkg::ctl_t                       ctl,
	output bpcw_pkg::sts_t                       sts,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bpcw_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

	import bpcw_pkg::*;

	localparam int CNT_W  = $clog2(MAX_BOXES + 1);
	localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int DVS_W  = ($clog2(MAX_BOXES + 2) > 4) ? $clog2(MAX_BOXES + 2) : 4;
	localparam int DIF_W  = COORD_BITS + 1;
	localparam int PRD_W  = 2 * DIF_W;
	localparam int PA_W   = 2 * COORD_BITS;
	localparam int BND_W  = RATIO_BITS + PA_W;
	localparam int AREA_W = PRD_W + 16;
	localparam int CMP_W  = BND_W + 2;
	localparam int ENT_W  = 4 * COORD_BITS;

	// configuration
	logic [COORD_BITS-1:0] pic_w_q, pic_h_q;
	logic [RATIO_BITS-1:0] min_q, max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pic_w_q <= RST_PIC_WIDTH;
			pic_h_q <= RST_PIC_HEIGHT;
			min_q   <= RST_MIN_RATIO;
			max_q   <= RST_MAX_RATIO;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PIC_WIDTH:  pic_w_q <= cfg_data[COORD_BITS-1:0];
				CFG_PIC_HEIGHT: pic_h_q <= cfg_data[COORD_BITS-1:0];
				CFG_MIN_RATIO:  min_q   <= cfg_data[RATIO_BITS-1:0];
				CFG_MAX_RATIO:  max_q   <= cfg_data[RATIO_BITS-1:0];
				default: ;
			endcase
		end
	end

	// item registers
	cmd_t                  cmd_q;
	logic [COORD_BITS-1:0] l_q, t_q, r_q, b_q;
	logic [CLICK_BITS-1:0] x_q, y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_NOP;
		end else if (ctl.op == OP_LOAD) begin
			cmd_q <= cmd_t'(s_tdata[1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD) begin
			l_q <= s_tdata[14:2];
			t_q <= s_tdata[27:15];
			r_q <= s_tdata[40:28];
			b_q <= s_tdata[53:41];
			x_q <= s_tdata[65:54];
			y_q <= s_tdata[77:66];
		end
	end

	// area filter
	logic signed [DIF_W-1:0]  aw, ah;
	logic signed [PRD_W-1:0]  prod_q;
	logic [PA_W-1:0]          pa_q;
	logic [BND_W-1:0]         blo_q, bhi_q;
	logic signed [AREA_W-1:0] area_sc;
	logic                     pass;
	logic                     store_full;

	always_comb begin
		aw         = $signed({1'b0, r_q}) - $signed({1'b0, l_q});
		ah         = $signed({1'b0, b_q}) - $signed({1'b0, t_q});
		area_sc    = $signed({prod_q, 16'b0});
		pass       = (pic_w_q != '0) && (pic_h_q != '0)
			&& ($signed({area_sc[AREA_W-1], area_sc}) > $signed({2'b0, blo_q}))
			&& ($signed({area_sc[AREA_W-1], area_sc}) < $signed({2'b0, bhi_q}));
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_MUL_WH: prod_q <= aw * ah;
			OP_MUL_PA: pa_q   <= pic_w_q * pic_h_q;
			OP_MUL_LO: blo_q  <= min_q * pa_q;
			OP_MUL_HI: bhi_q  <= max_q * pa_q;
			default: ;
		endcase
	end

	// store count and sums
	logic [CNT_W-1:0]    cnt_q;
	logic [SUM_BITS-1:0] wsum_q, hsum_q;
	logic                acc_q, full_q;
	logic                mem_we;

	assign store_full = (cnt_q >= CNT_W'(MAX_BOXES));
	assign mem_we     = (ctl.op == OP_ADD_DEC) && pass && !store_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wsum_q <= '0;
			hsum_q <= '0;
			acc_q  <= 1'b0;
			full_q <= 1'b0;
		end else begin
			case (ctl.op)
				OP_LOAD: begin
					acc_q  <= 1'b0;
					full_q <= 1'b0;
				end
				OP_CLEAR: begin
					cnt_q  <= '0;
					wsum_q <= '0;
					hsum_q <= '0;
				end
				OP_ADD_DEC: begin
					if (pass && store_full) begin
						full_q <= 1'b1;
					end else if (pass) begin
						cnt_q  <= cnt_q + 1'b1;
						wsum_q <= wsum_q + SUM_BITS'(aw);
						hsum_q <= hsum_q + SUM_BITS'(ah);
						acc_q  <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// box memory, registered read
	logic [ENT_W-1:0]  mem [MAX_BOXES];
	logic [ENT_W-1:0]  rd_s1;
	logic [CNT_W-1:0]  issue_q;
	logic [ADDR_W-1:0] raddr;

	assign raddr = issue_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[ADDR_W-1:0]] <= {b_q, r_q, t_q, l_q};
		end
		rd_s1 <= mem[raddr];
	end

	// scan pipeline: s1 read, s2 hit test and area, then best-so-far
	logic                     v_s1, v_s2, hit_s2;
	logic [ADDR_W-1:0]        idx_s1, idx_s2;
	logic [COORD_BITS-1:0]    el, et, er, eb, rc, bc;
	logic                     hit_c;
	logic signed [DIF_W-1:0]  dw_c, dh_c;
	logic signed [PRD_W-1:0]  area_s2;
	logic [COORD_BITS-1:0]    l_s2, t_s2, r_s2, b_s2;
	logic                     found_q;
	logic signed [PRD_W-1:0]  best_q;
	logic [ADDR_W-1:0]        best_idx_q;
	logic [COORD_BITS-1:0]    bl_q, bt_q, br_q, bb_q;
	logic                     scan_go;

	assign scan_go = (ctl.op == OP_SCAN) && (issue_q < cnt_q);

	always_comb begin
		el    = rd_s1[COORD_BITS-1:0];
		et    = rd_s1[2*COORD_BITS-1:COORD_BITS];
		er    = rd_s1[3*COORD_BITS-1:2*COORD_BITS];
		eb    = rd_s1[4*COORD_BITS-1:3*COORD_BITS];
		hit_c = ({1'b0, x_q} > el) && ({1'b0, x_q} < er)
			&& ({1'b0, y_q} > et) && ({1'b0, y_q} < eb);
		rc    = (er > pic_w_q) ? pic_w_q : er;
		bc    = (eb > pic_h_q) ? pic_h_q : eb;
		dw_c  = $signed({1'b0, rc}) - $signed({1'b0, el});
		dh_c  = $signed({1'b0, bc}) - $signed({1'b0, et});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			hit_s2  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1   <= scan_go;
			v_s2   <= v_s1;
			hit_s2 <= v_s1 && hit_c;
			if (ctl.op == OP_LOAD) begin
				issue_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (scan_go) begin
					issue_q <= issue_q + 1'b1;
				end
				if (hit_s2 && (!found_q || area_s2 < best_q)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= raddr;
		idx_s2  <= idx_s1;
		area_s2 <= dw_c * dh_c;
		l_s2    <= el;
		t_s2    <= et;
		r_s2    <= rc;
		b_s2    <= bc;
		if (ctl.op == OP_LOAD) begin
			best_idx_q <= '0;
		end else if (hit_s2 && (!found_q || area_s2 < best_q)) begin
			best_q     <= area_s2;
			best_idx_q <= idx_s2;
			bl_q       <= l_s2;
			bt_q       <= t_s2;
			br_q       <= r_s2;
			bb_q       <= b_s2;
		end
	end

	// shared divider
	logic                div_start, div_done;
	logic [SUM_BITS-1:0] div_dvd, div_q, qa_q, qb_q;
	logic [DVS_W-1:0]    div_dvs;
	logic                cnt_zero;

	assign cnt_zero  = (cnt_q == '0);
	assign div_start = (ctl.op == OP_DIV_START_A) || (ctl.op == OP_DIV_START_B);

	always_comb begin
		if (ctl.op == OP_DIV_START_B) begin
			div_dvd = cnt_zero ? SUM_BITS'(pic_h_q) : hsum_q;
		end else begin
			div_dvd = cnt_zero ? SUM_BITS'(pic_w_q) : wsum_q;
		end
		div_dvs = cnt_zero ? DVS_W'(EMPTY_DIV) : DVS_W'(cnt_q) + 1'b1;
	end

	bpcw_div #(
		.DVD_W(SUM_BITS),
		.DVS_W(DVS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.done(div_done),
		.quotient(div_q)
	);

	always_ff @(posedge clk) begin
		if (ctl.op == OP_DIV_WAIT_A && div_done) begin
			qa_q <= div_q;
		end
		if (ctl.op == OP_DIV_WAIT_B && div_done) begin
			qb_q <= div_q;
		end
	end

	// crop window
	logic signed [WIN_BITS-1:0] lox_q, hix_q, loy_q, hiy_q;
	logic signed [WIN_BITS-1:0] ssum, edge_v, half_hit, half_div;
	logic signed [WIN_BITS-1:0] cxh, cyh, cxc, cyc, lim_w, lim_h;
	logic signed [WIN_BITS-1:0] fx, fy;
	logic [SUM_BITS:0]          qsum;

	always_comb begin
		ssum     = WIN_BITS'($signed({1'b0, br_q}) - $signed({1'b0, bl_q}))
			+ WIN_BITS'($signed({1'b0, bb_q}) - $signed({1'b0, bt_q}));
		// halving that truncates toward zero
		edge_v   = (ssum + $signed({{(WIN_BITS-1){1'b0}}, ssum[WIN_BITS-1]})) >>> 1;
		half_hit = ((edge_v + $signed({{(WIN_BITS-1){1'b0}}, edge_v[WIN_BITS-1]})) >>> 1)
			+ WIN_BITS'(HALF_PAD);
		cxh      = $signed(WIN_BITS'(({1'b0, bl_q} + {1'b0, br_q}) >> 1));
		cyh      = $signed(WIN_BITS'(({1'b0, bt_q} + {1'b0, bb_q}) >> 1));
		qsum     = {1'b0, qa_q} + {1'b0, qb_q};
		half_div = $signed(WIN_BITS'(qsum >> 1))
			+ (cnt_zero ? WIN_BITS'(0) : WIN_BITS'(HALF_PAD));
		cxc      = $signed(WIN_BITS'(x_q));
		cyc      = $signed(WIN_BITS'(y_q));
		lim_w    = $signed(WIN_BITS'(pic_w_q));
		lim_h    = $signed(WIN_BITS'(pic_h_q));
		fx       = lox_q - (hix_q - lim_w);
		fy       = loy_q - (hiy_q - lim_h);
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				lox_q <= '0;
				hix_q <= '0;
				loy_q <= '0;
				hiy_q <= '0;
			end
			OP_WIN_HIT: begin
				lox_q <= cxh - half_hit;
				hix_q <= cxh + half_hit;
				loy_q <= cyh - half_hit;
				hiy_q <= cyh + half_hit;
			end
			OP_WIN_DIV: begin
				lox_q <= cxc - half_div;
				hix_q <= cxc + half_div;
				loy_q <= cyc - half_div;
				hiy_q <= cyc + half_div;
			end
			OP_FIT1: begin
				if (lox_q < 0) begin
					hix_q <= hix_q - lox_q;
					lox_q <= '0;
				end
				if (loy_q < 0) begin
					hiy_q <= hiy_q - loy_q;
					loy_q <= '0;
				end
			end
			OP_FIT2: begin
				if (hix_q > lim_w) begin
					lox_q <= (fx < 0) ? '0 : fx;
					hix_q <= lim_w;
				end
				if (hiy_q > lim_h) begin
					loy_q <= (fy < 0) ? '0 : fy;
					hiy_q <= lim_h;
				end
			end
			default: ;
		endcase
	end

	// result register
	logic                      out_valid_q;
	logic [OUT_TDATA_BITS-1:0] out_q;
	logic                      out_free;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_RESULT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_RESULT) begin
			out_q <= {2'b0, COUNT_BITS'(cnt_q),
				hiy_q[COORD_BITS-1:0], hix_q[COORD_BITS-1:0],
				loy_q[COORD_BITS-1:0], lox_q[COORD_BITS-1:0],
				INDEX_BITS'(best_idx_q), found_q, full_q, acc_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_comb begin
		sts.cmd       = cmd_q;
		sts.cnt_zero  = cnt_zero;
		sts.scan_done = (issue_q == cnt_q) && !v_s1 && !v_s2;
		sts.found     = found_q;
		sts.div_done  = div_done;
		sts.out_free  = out_free;
	end

endmodule

// File: design/bpcw_ctrl.sv
module bpcw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  bpcw_pkg::sts_t sts,
	output bpcw_pkg::ctl_t ctl
);

	import bpcw_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.op   = OP_NONE;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.op  = OP_LOAD;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.cmd)
					CMD_CLEAR: begin
						ctl.op  = OP_CLEAR;
						state_d = ST_DONE;
					end
					CMD_ADD:   state_d = ST_MUL_WH;
					CMD_QUERY: state_d = sts.cnt_zero ? ST_DIVA_START : ST_SCAN;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_MUL_WH: begin
				ctl.op  = OP_MUL_WH;
				state_d = ST_MUL_PA;
			end
			ST_MUL_PA: begin
				ctl.op  = OP_MUL_PA;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				ctl.op  = OP_MUL_LO;
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				ctl.op  = OP_MUL_HI;
				state_d = ST_ADD_DEC;
			end
			ST_ADD_DEC: begin
				ctl.op  = OP_ADD_DEC;
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				ctl.op = OP_SCAN;
				if (sts.scan_done) begin
					state_d = sts.found ? ST_WIN_HIT : ST_DIVA_START;
				end
			end
			ST_WIN_HIT: begin
				ctl.op  = OP_WIN_HIT;
				state_d = ST_FIT1;
			end
			ST_DIVA_START: begin
				ctl.op  = OP_DIV_START_A;
				state_d = ST_DIVA_WAIT;
			end
			ST_DIVA_WAIT: begin
				ctl.op = OP_DIV_WAIT_A;
				if (sts.div_done) begin
					state_d = ST_DIVB_START;
				end
			end
			ST_DIVB_START: begin
				ctl.op  = OP_DIV_START_B;
				state_d = ST_DIVB_WAIT;
			end
			ST_DIVB_WAIT: begin
				ctl.op = OP_DIV_WAIT_B;
				if (sts.div_done) begin
					state_d = ST_WIN_DIV;
				end
			end
			ST_WIN_DIV: begin
				ctl.op  = OP_WIN_DIV;
				state_d = ST_FIT1;
			end
			ST_FIT1: begin
				ctl.op  = OP_FIT1;
				state_d = ST_FIT2;
			end
			ST_FIT2: begin
				ctl.op  = OP_FIT2;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.op  = OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: design/box_pick_crop_window.sv
// Clear and no-op pass straight to the result; add runs the area-filter multiplies, then
// the store decision; query scans the N stored boxes (one box read per cycle from the box
// memory) and on a hit centres the window on the smallest hit box; a query without a hit
// or on an empty store runs the two 20-step divisions in the shared bit-serial divider.
// One item at a time: the next beat is taken once the previous result sits in the
// output register. Reset (arst_n low) empties the store and loads default config.
module box_pick_crop_window #(
	parameter int MAX_BOXES = bpcw_pkg::DEF_MAX_BOXES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port, index 0..3: width, height, min ratio, max ratio
	input  logic                                cfg_we,
	input  logic [bpcw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bpcw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// input beats
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// command[1:0], box_left, box_top, box_right, box_bottom, click_x, click_y
	input  logic [bpcw_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	// result beats
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// accepted, store_full, hit, hit_index[6:0], crop_left, crop_top,
	// crop_right, crop_bottom, box_count[7:0]
	output logic [bpcw_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

	import bpcw_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer: one state per step of the add / query flow
	bpcw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.ctl(ctl)
	);

	// box memory, area filter, scan pipeline, divider and window fitting
	bpcw_datapath #(
		.MAX_BOXES(MAX_BOXES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tdata(s_tdata),
		.ctl(ctl),
		.sts(sts),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// File: bench/box_pick_crop_window_check.sv
`timescale 1ns / 1ps

// Watches both channels and the config port, predicts every result and compares.
module box_pick_crop_window_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bpcw_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [bpcw_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [bpcw_pkg::IN_TDATA_BITS-1:0]  s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [bpcw_pkg::OUT_TDATA_BITS-1:0] m_tdata,
	output int                                  pending,
	output int                                  fails
);

	import bpcw_pkg::*;

	typedef struct packed {
		logic [7:0]            count;
		logic [COORD_BITS-1:0] bottom;
		logic [COORD_BITS-1:0] right;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] left;
		logic [6:0]            index;
		logic                  hit;
		logic                  full;
		logic                  accepted;
	} crop_result_t;

	crop_result_t crop_q[$];

	logic [COORD_BITS-1:0] box_l[DEF_MAX_BOXES];
	logic [COORD_BITS-1:0] box_t[DEF_MAX_BOXES];
	logic [COORD_BITS-1:0] box_r[DEF_MAX_BOXES];
	logic [COORD_BITS-1:0] box_b[DEF_MAX_BOXES];
	int unsigned           n_boxes;
	logic [SUM_BITS-1:0]   w_sum, h_sum;
	logic [COORD_BITS-1:0] pic_w, pic_h;
	logic [RATIO_BITS-1:0] ratio_lo, ratio_hi;

	function automatic void fit_span(inout longint lo, inout longint hi, input longint lim);
		if (lo < 0) begin
			hi = hi - lo;
			lo = 0;
		end
		if (hi > lim) begin
			lo = lo - (hi - lim);
			if (lo < 0)
				lo = 0;
			hi = lim;
		end
	endfunction

	function automatic crop_result_t predict_crop(logic [IN_TDATA_BITS-1:0] d);
		crop_result_t res;
		cmd_t         cmd;
		longint       l, t, r, b, x, y, area, pa, wd, ht, half, n1;
		longint       cl, ct, cr, cb, best, bl, bt, br, bb, a;
		bit           found;
		cmd   = cmd_t'(d[1:0]);
		l     = d[14:2];
		t     = d[27:15];
		r     = d[40:28];
		b     = d[53:41];
		x     = d[65:54];
		y     = d[77:66];
		res   = '0;
		cl = 0; ct = 0; cr = 0; cb = 0;
		wd    = pic_w;
		ht    = pic_h;
		case (cmd)
			CMD_CLEAR: begin
				n_boxes = 0;
				w_sum   = '0;
				h_sum   = '0;
			end
			CMD_ADD: begin
				area = (r - l) * (b - t) * 65536;
				pa   = wd * ht;
				if (pa > 0 && area > longint'(ratio_lo) * pa && area < longint'(ratio_hi) * pa) begin
					if (n_boxes >= DEF_MAX_BOXES) begin
						res.full = 1'b1;
					end else begin
						box_l[n_boxes] = COORD_BITS'(l);
						box_t[n_boxes] = COORD_BITS'(t);
						box_r[n_boxes] = COORD_BITS'(r);
						box_b[n_boxes] = COORD_BITS'(b);
						n_boxes++;
						w_sum = w_sum + SUM_BITS'(r - l);
						h_sum = h_sum + SUM_BITS'(b - t);
						res.accepted = 1'b1;
					end
				end
			end
			CMD_QUERY: begin
				if (n_boxes == 0) begin
					half = (wd / 10 + ht / 10) / 2;
					cl = x - half; cr = x + half; ct = y - half; cb = y + half;
				end else begin
					found = 0;
					best = 0; bl = 0; bt = 0; br = 0; bb = 0;
					for (int i = 0; i < n_boxes; i++) begin
						l = box_l[i]; t = box_t[i]; r = box_r[i]; b = box_b[i];
						if (x > l && x < r && y > t && y < b) begin
							if (r > wd) r = wd;
							if (b > ht) b = ht;
							a = (r - l) * (b - t);
							if (!found || a < best) begin
								found     = 1;
								best      = a;
								res.index = INDEX_BITS'(i);
								bl = l; bt = t; br = r; bb = b;
							end
						end
					end
					if (found) begin
						half    = (((br - bl) + (bb - bt)) / 2) / 2 + 15;
						res.hit = 1'b1;
						cl = (bl + br) / 2 - half; cr = (bl + br) / 2 + half;
						ct = (bt + bb) / 2 - half; cb = (bt + bb) / 2 + half;
					end else begin
						n1   = n_boxes + 1;
						half = (longint'(w_sum) / n1 + longint'(h_sum) / n1) / 2 + 15;
						cl = x - half; cr = x + half; ct = y - half; cb = y + half;
					end
				end
				fit_span(cl, cr, wd);
				fit_span(ct, cb, ht);
			end
			default: ;
		endcase
		res.left   = cl[12:0];
		res.top    = ct[12:0];
		res.right  = cr[12:0];
		res.bottom = cb[12:0];
		res.count  = n_boxes[7:0];
		return res;
	endfunction

	task automatic compare_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		crop_result_t want, got;
		if (!arst_n) begin
			n_boxes  = 0;
			w_sum    = '0;
			h_sum    = '0;
			pic_w    = RST_PIC_WIDTH;
			pic_h    = RST_PIC_HEIGHT;
			ratio_lo = RST_MIN_RATIO;
			ratio_hi = RST_MAX_RATIO;
			crop_q.delete();
			pending  = 0;
			fails    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PIC_WIDTH:  pic_w    = cfg_data[COORD_BITS-1:0];
					CFG_PIC_HEIGHT: pic_h    = cfg_data[COORD_BITS-1:0];
					CFG_MIN_RATIO:  ratio_lo = cfg_data;
					CFG_MAX_RATIO:  ratio_hi = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				crop_q.push_back(predict_crop(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(crop_result_t)-1:0];
				if (crop_q.size() == 0) begin
					$error("result beat with nothing expected");
					fails++;
				end else begin
					want = crop_q.pop_front();
					compare_field("accepted", want.accepted, got.accepted);
					compare_field("store_full", want.full, got.full);
					compare_field("hit", want.hit, got.hit);
					compare_field("hit_index", want.index, got.index);
					compare_field("crop_left", want.left, got.left);
					compare_field("crop_top", want.top, got.top);
					compare_field("crop_right", want.right, got.right);
					compare_field("crop_bottom", want.bottom, got.bottom);
					compare_field("box_count", want.count, got.count);
				end
			end
			pending = crop_q.size();
		end
	end

endmodule

// File: bench/box_pick_crop_window_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict; prediction and comparison live in the checker.
module box_pick_crop_window_test;
	import bpcw_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	int                        pending, fails;

	// idle pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
	int idle_mode = 0;
	int unsigned pic_w = 640, pic_h = 480;
	int unsigned idle_cycles = 0;
	// recent add boxes, used to aim clicks inside them
	int unsigned aim_l[$], aim_t[$], aim_r[$], aim_b[$];

	always #5 clk = ~clk;

	box_pick_crop_window dut (.*);

	box_pick_crop_window_check checker_i (.*);

	// receiver: stalls 48 percent of the time in mode 2, 24 percent in mode 3
	always @(posedge clk)
		m_tready <= (idle_mode >= 2) ?
			($urandom_range(0, 99) >= ((idle_mode == 3) ? 24 : 48)) : 1'b1;

	// watchdog: counts cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("box_pick_crop_window_test failed");
			$finish;
		end
	end

	function automatic logic [IN_TDATA_BITS-1:0] pack_beat(cmd_t cmd, int unsigned l, int unsigned t,
			int unsigned r, int unsigned b, int unsigned x, int unsigned y);
		return {2'b00, y[11:0], x[11:0], b[12:0], r[12:0], t[12:0], l[12:0], cmd};
	endfunction

	// first idles at random, with a chance of 48 percent (mode 1) or 24 percent (mode 3) per try, then holds the beat
	task automatic send_beat(logic [IN_TDATA_BITS-1:0] d);
		int pct;
		pct = (idle_mode == 3) ? 24 : 48;
		if (idle_mode == 1 || idle_mode == 3) begin
			while ($urandom_range(0, 99) < pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic add_box(int unsigned l, int unsigned t, int unsigned r, int unsigned b);
		aim_l.push_back(l); aim_t.push_back(t); aim_r.push_back(r); aim_b.push_back(b);
		if (aim_l.size() > 16) begin
			void'(aim_l.pop_front()); void'(aim_t.pop_front());
			void'(aim_r.pop_front()); void'(aim_b.pop_front());
		end
		send_beat(pack_beat(CMD_ADD, l, t, r, b, $urandom_range(0, 4095), $urandom_range(0, 4095)));
	endtask

	task automatic click(int unsigned x, int unsigned y);
		send_beat(pack_beat(CMD_QUERY, $urandom_range(0, 4096), $urandom_range(0, 4096),
			$urandom_range(0, 4096), $urandom_range(0, 4096), x, y));
	endtask

	// waits for every result with the sender idle, then stays quiet before returning
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_config(int unsigned w, int unsigned h, int unsigned lo, int unsigned hi);
		drain();
		write_reg(CFG_PIC_WIDTH, w);
		write_reg(CFG_PIC_HEIGHT, h);
		write_reg(CFG_MIN_RATIO, lo);
		write_reg(CFG_MAX_RATIO, hi);
		pic_w = w;
		pic_h = h;
		idle_mode = (idle_mode + 1) % 4;
	endtask

	// mostly well-formed adds and clicks aimed at recently added boxes, some noise
	task automatic random_beats(int n, int add_pct);
		int unsigned l, t, w, h, k, pw, ph;
		int          roll;
		pw = (pic_w == 0) ? 1 : pic_w;
		ph = (pic_h == 0) ? 1 : pic_h;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < add_pct) begin
				w = $urandom_range(1, pw);
				h = $urandom_range(1, ph);
				if ($urandom_range(0, 3) == 0) begin
					w = $urandom_range(1, (pw + 3) / 4);
					h = $urandom_range(1, (ph + 3) / 4);
				end
				l = $urandom_range(0, pw - w);
				t = $urandom_range(0, ph - h);
				add_box(l, t, l + w, t + h);
			end else if (roll < add_pct + 30) begin
				if (aim_l.size() > 0 && $urandom_range(0, 9) < 7) begin
					k = $urandom_range(0, aim_l.size() - 1);
					click((aim_r[k] > aim_l[k] + 1) ?
						$urandom_range(aim_l[k] + 1, aim_r[k] - 1) % 4096 : aim_l[k] % 4096,
						(aim_b[k] > aim_t[k] + 1) ?
						$urandom_range(aim_t[k] + 1, aim_b[k] - 1) % 4096 : aim_t[k] % 4096);
				end else begin
					click($urandom_range(0, 4095), $urandom_range(0, 4095));
				end
			end else if (roll < add_pct + 33) begin
				send_beat(pack_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
			end else begin
				// noise: any command, any field values
				send_beat(pack_beat(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 4096),
					$urandom_range(0, 4096), $urandom_range(0, 4096), $urandom_range(0, 4096),
					$urandom_range(0, 4095), $urandom_range(0, 4095)));
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset config 640 x 480
		send_beat(pack_beat(CMD_NOP, 4096, 4096, 4096, 4096, 4095, 4095));
		click(100, 100);                       // empty store
		add_box(10, 20, 200, 300);
		add_box(10, 20, 200, 300);             // equal area: lower index must win
		add_box(50, 60, 100, 110);             // smaller nested box
		add_box(500, 400, 700, 600);           // overhangs the picture, clamped on a hit
		add_box(300, 300, 100, 100);           // reversed edges
		add_box(0, 0, 0, 0);                   // zero area
		add_box(0, 0, 4096, 4096);             // above upper bound
		add_box(0, 0, 1, 1);                   // below lower bound
		click(150, 250);                       // tie
		click(75, 80);                         // nested
		click(600, 450);                       // clamped box, shifted
		click(5, 5);                           // miss near corner, average size
		click(10, 25);                         // on an edge, not strictly inside
		click(4095, 4095);                     // far outside, clipped
		click(0, 0);
		send_beat(pack_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		click(639, 479);

		random_beats(100, 45);

		// wide picture, open bounds: fill the store past full
		set_config(4096, 4096, 0, 65536);
		send_beat(pack_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		repeat (135) add_box($urandom_range(0, 2000), $urandom_range(0, 2000),
			$urandom_range(2001, 4096), $urandom_range(2001, 4096));
		random_beats(40, 20);

		// one pixel picture: nothing can pass
		set_config(1, 1, 0, 65536);
		random_beats(25, 40);

		// zero width picture
		set_config(0, 4096, 66, 52429);
		random_beats(20, 40);

		set_config(1024, 768, 1000, 30000);
		send_beat(pack_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
		random_beats(150, 45);

		// inverted bounds
		set_config(4096, 17, 65536, 0);
		random_beats(20, 40);

		repeat (3) begin
			set_config($urandom_range(1, 4096), $urandom_range(1, 4096),
				$urandom_range(0, 3000), $urandom_range(20000, 65536));
			if ($urandom_range(0, 1))
				send_beat(pack_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
			random_beats(70, 45);
		end

		drain();
		if (fails == 0)
			$display("box_pick_crop_window_test passed");
		else
			$display("box_pick_crop_window_test failed");
		$finish;
	end

endmodule
